>>> hw/rtl/cdrs_pkg.sv
// Shared types and constants for the counter delta/rate/share unit.
// Depends on nothing; imported by cdrs_ctrl, cdrs_dp and the top level.
package cdrs_pkg;

  // Fixed field widths
  localparam int unsigned CNT_W   = 64;  // cumulative counter width
  localparam int unsigned TIME_W  = 63;  // sample time width (ms)
  localparam int unsigned BS_W    = 22;  // bucket_seconds width
  localparam int unsigned DIV_W   = 65;  // divisor width (share total needs a carry bit)
  localparam int unsigned SCALE_W = 16;  // width of the small scale constants
  localparam int unsigned PROD_W  = CNT_W + SCALE_W;
  localparam int unsigned QUO_W   = 64;  // quotient bits produced by the divider
  localparam int unsigned ITER_W  = $clog2(QUO_W);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = BS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SCOPE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN_SCOPE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SEC  = 2'd3;

  // Series kinds (any other code means share)
  localparam logic [1:0] KIND_LEVEL = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;

  // Scale constants: ms per minute, s per minute, percent
  localparam logic [SCALE_W-1:0] SCALE_MIN_MS = 16'd60000;
  localparam logic [SCALE_W-1:0] SCALE_MIN_S  = 16'd60;
  localparam logic [SCALE_W-1:0] SCALE_PCT    = 16'd100;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_ANSWER  = 3'd1,
    ST_NO_PRIOR   = 3'd2,
    ST_RESTART    = 3'd3,
    ST_NO_TRAFFIC = 3'd4
  } cdrs_status_e;

  typedef struct packed {
    logic [1:0]      series_kind;
    logic            num_scope;
    logic            den_scope;
    logic [BS_W-1:0] bucket_seconds;
  } cdrs_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic eval;     // classify, form deltas, update the kept bucket
    logic mul;      // form delta * scale
    logic load;     // saturation check, seed the divider
    logic step;     // one quotient bit
    logic emit;     // load the output register
  } cdrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic sat;
  } cdrs_sts_t;

endpackage

>>> hw/rtl/cdrs_ctrl.sv
// Sequencer for the counter delta/rate/share unit.
// Depends on cdrs_pkg; drives cdrs_dp through cdrs_cmd_t.
module cdrs_ctrl
  import cdrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  cdrs_sts_t sts_i,
  output cdrs_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_MUL  = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } cdrs_state_e;

  cdrs_state_e       state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_div ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        iter_d     = '0;
        state_d    = sts_i.sat ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        iter_d     = iter_q + 1'b1;
        if (iter_q == ITER_W'(QUO_W - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/cdrs_dp.sv
// Datapath for the counter delta/rate/share unit: kept bucket, classifier,
// scale multiplier, bit-serial divider and output register. Depends on cdrs_pkg.
module cdrs_dp
  import cdrs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdrs_cfg_t         cfg_i,
  input  cdrs_cmd_t         cmd_i,
  output cdrs_sts_t         sts_o,
  input  logic              first_bucket_i,
  input  logic              present_i,
  input  logic              backfilled_i,
  input  logic [CNT_W-1:0]  numerator_count_i,
  input  logic [CNT_W-1:0]  denominator_count_i,
  input  logic [TIME_W-1:0] sample_millis_i,
  output logic              value_valid_o,
  output logic [CNT_W-1:0]  value_o,
  output logic [2:0]        status_o
);

  localparam int unsigned NHI_W = PROD_W - QUO_W + FRAC_BITS;

  // captured request
  logic              first_q, present_q, backfilled_q;
  logic [CNT_W-1:0]  num_q, den_q;
  logic [TIME_W-1:0] tms_q;

  // kept bucket
  logic              prior_valid_q, prior_answers_q, prior_backfilled_q;
  logic [CNT_W-1:0]  prior_num_q, prior_den_q;
  logic [TIME_W-1:0] prior_tms_q;

  // work registers
  logic               res_valid_q, div_q, sat_q;
  logic [CNT_W-1:0]   res_value_q;
  cdrs_status_e       res_status_q;
  logic [CNT_W-1:0]   dn_q;
  logic [SCALE_W-1:0] scale_q;
  logic [DIV_W-1:0]   dvsr_q, rem_q;
  logic [PROD_W-1:0]  prod_q;
  logic [QUO_W-1:0]   quo_q;

  // output register
  logic               out_vvalid_q;
  logic [CNT_W-1:0]   out_value_q;
  cdrs_status_e       out_status_q;

  // classification
  logic               answers, comparable, span_pos;
  logic [CNT_W-1:0]   dn, dd, level_val;
  logic [DIV_W-1:0]   total;
  logic [TIME_W-1:0]  span;
  logic               ev_div, ev_valid;
  logic [CNT_W-1:0]   ev_value;
  cdrs_status_e       ev_status;
  logic [SCALE_W-1:0] ev_scale;
  logic [DIV_W-1:0]   ev_dvsr;

  // divider
  logic [NHI_W-1:0]   n_hi;
  logic [QUO_W-1:0]   n_lo;
  logic               sat;
  logic [DIV_W:0]     trial, diff;
  logic               qbit;

  assign answers    = present_q &&
                      (!backfilled_q || (cfg_i.num_scope && cfg_i.den_scope));
  assign comparable = !first_q && prior_valid_q && prior_answers_q &&
                      (prior_backfilled_q == backfilled_q);
  assign dn         = num_q - prior_num_q;
  assign dd         = den_q - prior_den_q;
  assign total      = {1'b0, dn} + {1'b0, dd};
  assign span       = tms_q - prior_tms_q;
  assign span_pos   = tms_q > prior_tms_q;
  assign level_val  = (|num_q[CNT_W-1 -: FRAC_BITS]) ? '1 : (num_q << FRAC_BITS);

  always_comb begin
    ev_div    = 1'b0;
    ev_valid  = 1'b0;
    ev_value  = '0;
    ev_status = ST_OK;
    ev_scale  = SCALE_PCT;
    ev_dvsr   = total;
    priority if (!answers) begin
      ev_status = ST_NO_ANSWER;
    end else if (cfg_i.series_kind == KIND_LEVEL) begin
      ev_valid = 1'b1;
      ev_value = level_val;
    end else if (!comparable) begin
      ev_status = ST_NO_PRIOR;
    end else if (num_q < prior_num_q) begin
      ev_status = ST_RESTART;
    end else if (cfg_i.series_kind == KIND_RATE) begin
      ev_valid = 1'b1;
      if (span_pos) begin
        ev_div   = 1'b1;
        ev_scale = SCALE_MIN_MS;
        ev_dvsr  = DIV_W'(span);
      end else if (cfg_i.bucket_seconds != '0) begin
        ev_div   = 1'b1;
        ev_scale = SCALE_MIN_S;
        ev_dvsr  = DIV_W'(cfg_i.bucket_seconds);
      end
    end else if (den_q < prior_den_q) begin
      ev_status = ST_RESTART;
    end else if (total == '0) begin
      ev_status = ST_NO_TRAFFIC;
    end else begin
      ev_div   = 1'b1;
      ev_valid = 1'b1;
    end
  end

  // dividend = prod << FRAC_BITS, split at the quotient width
  assign n_hi  = prod_q[PROD_W-1 -: NHI_W];
  assign n_lo  = {prod_q[QUO_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign sat   = DIV_W'(n_hi) >= dvsr_q;
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign qbit  = trial >= {1'b0, dvsr_q};
  assign diff  = qbit ? (trial - {1'b0, dvsr_q}) : trial;

  assign sts_o.need_div = ev_div;
  assign sts_o.sat      = sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_valid_q      <= 1'b0;
      prior_answers_q    <= 1'b0;
      prior_backfilled_q <= 1'b0;
      prior_num_q        <= '0;
      prior_den_q        <= '0;
      prior_tms_q        <= '0;
    end else if (cmd_i.eval) begin
      // every request replaces the kept bucket
      prior_valid_q      <= 1'b1;
      prior_answers_q    <= answers;
      prior_backfilled_q <= backfilled_q;
      prior_num_q        <= num_q;
      prior_den_q        <= den_q;
      prior_tms_q        <= tms_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      first_q      <= first_bucket_i;
      present_q    <= present_i;
      backfilled_q <= backfilled_i;
      num_q        <= numerator_count_i;
      den_q        <= denominator_count_i;
      tms_q        <= sample_millis_i;
    end
    if (cmd_i.eval) begin
      res_valid_q  <= ev_valid;
      res_value_q  <= ev_value;
      res_status_q <= ev_status;
      div_q        <= ev_div;
      dn_q         <= dn;
      scale_q      <= ev_scale;
      dvsr_q       <= ev_dvsr;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(dn_q) * PROD_W'(scale_q);
    end
    if (cmd_i.load) begin
      sat_q <= sat;
      rem_q <= DIV_W'(n_hi);
      quo_q <= n_lo;
    end
    if (cmd_i.step) begin
      rem_q <= diff[DIV_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], qbit};
    end
    if (cmd_i.emit) begin
      out_vvalid_q <= res_valid_q;
      out_status_q <= res_status_q;
      priority if (!res_valid_q) begin
        out_value_q <= '0;
      end else if (div_q) begin
        out_value_q <= sat_q ? '1 : quo_q;
      end else begin
        out_value_q <= res_value_q;
      end
    end
  end

  assign value_valid_o = out_vvalid_q;
  assign value_o       = out_value_q;
  assign status_o      = out_status_q;

endmodule

>>> hw/rtl/counter_delta_rate_share.sv
// Top level of the counter delta/rate/share unit.
// Depends on cdrs_pkg, cdrs_ctrl and cdrs_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one sampled bucket per
//   request. Output channel (out_valid_o/out_ready_i) returns exactly one
//   reading per request: value_valid_o, value_o (unsigned Q(64-F).F) and
//   status_o. Config channel (cfg_valid_i/cfg_ready_o) is always ready;
//   write it only while no request is in flight.
// Sequence:
//   Level readings, absent values and rate with no divisor go from accept
//   through classify to emit; saturated divides add the multiply and
//   saturation-check steps; other rate and share readings also run the
//   one-bit-per-cycle 64-step divider before the emit. The next request
//   is taken in the cycle after the emit.
// Reset:
//   Clears the kept bucket (next rate/share reading reports no prior) and
//   loads series_kind 0, both scopes 1, bucket_seconds 60.
// Stall:
//   A finished result waits in the output register; one further request is
//   accepted and worked on meanwhile, and then holds before its emit step.
module counter_delta_rate_share
  import cdrs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // bucket requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  first_bucket_i,
  input  logic                  present_i,
  input  logic                  backfilled_i,
  input  logic [CNT_W-1:0]      numerator_count_i,
  input  logic [CNT_W-1:0]      denominator_count_i,
  input  logic [TIME_W-1:0]     sample_millis_i,
  // readings
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  value_valid_o,
  output logic [CNT_W-1:0]      value_o,
  output logic [2:0]            status_o
);

  cdrs_cfg_t cfg_q;
  cdrs_cmd_t cmd;
  cdrs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Register file: every index of the 2-bit space names a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.series_kind    <= KIND_LEVEL;
      cfg_q.num_scope      <= 1'b1;
      cfg_q.den_scope      <= 1'b1;
      cfg_q.bucket_seconds <= BS_W'(60);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SERIES_KIND: cfg_q.series_kind    <= cfg_data_i[1:0];
        CFG_NUM_SCOPE:   cfg_q.num_scope      <= cfg_data_i[0];
        CFG_DEN_SCOPE:   cfg_q.den_scope      <= cfg_data_i[0];
        CFG_BUCKET_SEC:  cfg_q.bucket_seconds <= cfg_data_i[BS_W-1:0];
        default:         cfg_q                <= cfg_q;
      endcase
    end
  end

  // Sequencer: accept, classify, multiply, check, divide, emit.
  cdrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Kept bucket, arithmetic and the output register.
  cdrs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .first_bucket_i      (first_bucket_i),
    .present_i           (present_i),
    .backfilled_i        (backfilled_i),
    .numerator_count_i   (numerator_count_i),
    .denominator_count_i (denominator_count_i),
    .sample_millis_i     (sample_millis_i),
    .value_valid_o       (value_valid_o),
    .value_o             (value_o),
    .status_o            (status_o)
  );

  // A request occupies the unit: no second accept on the next edge.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted back to back");

  // An absent reading carries zero.
  a_absent_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !value_valid_o |-> value_o == '0)
    else $error("absent reading with nonzero value");

  // Only the ok status goes with a reading.
  a_valid_iff_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_valid_o == (status_o == ST_OK)))
    else $error("reading flag and status disagree");

endmodule
